// File: src/bass_pkg.sv
// Shared constants, codes and types of the bounded array store with search and sort.
package bass_pkg;

    localparam int CAPACITY = 8;
    localparam int DATA_W   = 32;
    localparam int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW       = $clog2(CAPACITY + 1);
    localparam int IDX_W    = 3;

    typedef enum logic [2:0] {
        KIND_INSERT  = 3'd0,
        KIND_DELETE  = 3'd1,
        KIND_DISPLAY = 3'd2,
        KIND_SEARCH  = 3'd3,
        KIND_SORT    = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_INVALID  = 3'd4
    } t_status;

    typedef enum logic {
        CMP_EQ  = 1'b0,
        CMP_SGT = 1'b1
    } t_cmp_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_DEL,
        S_DISP_RD,
        S_DISP_OUT,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_SORT_RD,
        S_SORT_CMP,
        S_SORT_WB,
        S_REPLY
    } t_state;

endpackage

// File: src/bounded_array_stack_search_sort_top.sv
// Top level of the bounded array store with insert, delete, display, search and sort.
//
// The input channel carries one operation per transaction (i_kind, i_value) under
// i_valid and o_stall; the output channel returns results (o_status, o_data,
// o_index, o_last) under o_valid and i_stall. o_last marks the final result of
// an operation. Operations run one at a time: o_stall is high from the cycle
// after acceptance until the last result has been loaded into the output register.
// The elements sit in a small memory with registered reads, and a single compare
// unit steps through them under a sequencer:
//   insert, invalid kind, empty store: the result is decided at decode;
//   delete: reads the last element before replying; display: reads and returns
//   each element in turn; search: compares each element until a hit or the last one;
//   sort: reads and compares each pair and writes an exchanged pair back.
// A synchronous reset empties the store and clears both channels; element
// contents are not cleared. While the receiver stalls, the output register holds
// its result and the sequencer waits before loading the next one.
module bounded_array_stack_search_sort_top
    import bass_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic        [2:0]        i_kind,
    input  logic signed [DATA_W-1:0] i_value,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic        [2:0]        o_status,
    output logic signed [DATA_W-1:0] o_data,
    output logic        [IDX_W-1:0]  o_index,
    output logic                     o_last
);

    logic [DATA_W-1:0] r_mem [CAPACITY];

    t_state            r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [CW-1:0]     r_i, n_i;
    logic [CW-1:0]     r_j, n_j;
    logic [2:0]        r_kind, n_kind;
    logic [DATA_W-1:0] r_key, n_key;
    t_status           r_status, n_status;
    logic [DATA_W-1:0] r_data, n_data;
    logic [IDX_W-1:0]  r_index, n_index;
    logic [DATA_W-1:0] r_rda, r_rdb;

    logic              r_o_valid;
    t_status           r_o_status;
    logic [DATA_W-1:0] r_o_data;
    logic [IDX_W-1:0]  r_o_index;
    logic              r_o_last;

    logic              mem_we;
    logic [AW-1:0]     mem_wa;
    logic [DATA_W-1:0] mem_wd;
    logic              rd_en;
    logic [AW-1:0]     ra, rb;
    t_cmp_op           cmp_op;
    logic [DATA_W-1:0] cmp_b;
    logic              cmp_hit;
    logic              out_load;
    t_status           out_status;
    logic [DATA_W-1:0] out_data;
    logic [IDX_W-1:0]  out_index;
    logic              out_last;
    logic              slot_free;
    logic              item_last;
    logic              sort_more_j;
    logic              sort_more_i;

    assign slot_free   = !r_o_valid || !i_stall;
    assign item_last   = ((r_i + CW'(1)) == r_count);
    assign sort_more_j = ((r_j + CW'(1)) < r_count);
    assign sort_more_i = ((r_i + CW'(2)) < r_count);
    assign cmp_b       = (cmp_op == CMP_EQ) ? r_key : r_rdb;

    bass_cmp u_cmp (
        .i_op  (cmp_op),
        .i_a   (r_rda),
        .i_b   (cmp_b),
        .o_hit (cmp_hit)
    );

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (rd_en) begin
            r_rda <= r_mem[ra];
            r_rdb <= r_mem[rb];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i      <= n_i;
        r_j      <= n_j;
        r_kind   <= n_kind;
        r_key    <= n_key;
        r_status <= n_status;
        r_data   <= n_data;
        r_index  <= n_index;
    end

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_i        = r_i;
        n_j        = r_j;
        n_kind     = r_kind;
        n_key      = r_key;
        n_status   = r_status;
        n_data     = r_data;
        n_index    = r_index;
        mem_we     = 1'b0;
        mem_wa     = r_i[AW-1:0];
        mem_wd     = r_rdb;
        rd_en      = 1'b0;
        ra         = r_i[AW-1:0];
        rb         = r_j[AW-1:0];
        cmp_op     = CMP_EQ;
        out_load   = 1'b0;
        out_status = r_status;
        out_data   = r_data;
        out_index  = r_index;
        out_last   = 1'b1;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_kind  = i_kind;
                    n_key   = i_value;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_status = ST_OK;
                n_data   = '0;
                n_index  = '0;
                n_i      = '0;
                n_j      = CW'(1);
                n_state  = S_REPLY;
                case (t_kind'(r_kind))
                    KIND_INSERT: begin
                        if (r_count == CW'(CAPACITY)) begin
                            n_status = ST_FULL;
                        end else begin
                            mem_we  = 1'b1;
                            mem_wa  = r_count[AW-1:0];
                            mem_wd  = r_key;
                            n_count = r_count + CW'(1);
                            n_data  = r_key;
                        end
                    end
                    KIND_DELETE: begin
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                        end else begin
                            rd_en   = 1'b1;
                            n_count = r_count - CW'(1);
                            ra      = n_count[AW-1:0];
                            n_state = S_DEL;
                        end
                    end
                    KIND_DISPLAY: begin
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                        end else begin
                            n_state = S_DISP_RD;
                        end
                    end
                    KIND_SEARCH: begin
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                        end else begin
                            n_state = S_SRCH_RD;
                        end
                    end
                    KIND_SORT: begin
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                        end else if (r_count != CW'(1)) begin
                            n_state = S_SORT_RD;
                        end
                    end
                    default: begin
                        n_status = ST_INVALID;
                    end
                endcase
            end
            S_DEL: begin
                n_data  = r_rda;
                n_state = S_REPLY;
            end
            S_DISP_RD: begin
                rd_en   = 1'b1;
                n_state = S_DISP_OUT;
            end
            S_DISP_OUT: begin
                out_status = ST_OK;
                out_data   = r_rda;
                out_index  = IDX_W'(r_i);
                out_last   = item_last;
                if (slot_free) begin
                    out_load = 1'b1;
                    if (item_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_i     = r_i + CW'(1);
                        n_state = S_DISP_RD;
                    end
                end
            end
            S_SRCH_RD: begin
                rd_en   = 1'b1;
                n_state = S_SRCH_CMP;
            end
            S_SRCH_CMP: begin
                cmp_op = CMP_EQ;
                if (cmp_hit) begin
                    n_data  = r_key;
                    n_index = IDX_W'(r_i);
                    n_state = S_REPLY;
                end else if (item_last) begin
                    n_status = ST_NOTFOUND;
                    n_state  = S_REPLY;
                end else begin
                    n_i     = r_i + CW'(1);
                    n_state = S_SRCH_RD;
                end
            end
            S_SORT_RD: begin
                rd_en   = 1'b1;
                n_state = S_SORT_CMP;
            end
            S_SORT_CMP: begin
                cmp_op = CMP_SGT;
                if (cmp_hit) begin
                    mem_we  = 1'b1;
                    mem_wa  = r_i[AW-1:0];
                    mem_wd  = r_rdb;
                    n_state = S_SORT_WB;
                end else if (sort_more_j) begin
                    n_j     = r_j + CW'(1);
                    n_state = S_SORT_RD;
                end else if (sort_more_i) begin
                    n_i     = r_i + CW'(1);
                    n_j     = r_i + CW'(2);
                    n_state = S_SORT_RD;
                end else begin
                    n_state = S_REPLY;
                end
            end
            S_SORT_WB: begin
                mem_we = 1'b1;
                mem_wa = r_j[AW-1:0];
                mem_wd = r_rda;
                if (sort_more_j) begin
                    n_j     = r_j + CW'(1);
                    n_state = S_SORT_RD;
                end else if (sort_more_i) begin
                    n_i     = r_i + CW'(1);
                    n_j     = r_i + CW'(2);
                    n_state = S_SORT_RD;
                end else begin
                    n_state = S_REPLY;
                end
            end
            S_REPLY: begin
                if (slot_free) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_load) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_status <= out_status;
            r_o_data   <= out_data;
            r_o_index  <= out_index;
            r_o_last   <= out_last;
        end
    end

    assign o_stall  = (r_state != S_IDLE);
    assign o_valid  = r_o_valid;
    assign o_status = r_o_status;
    assign o_data   = r_o_data;
    assign o_index  = r_o_index;
    assign o_last   = r_o_last;

endmodule

// File: src/bass_cmp.sv
// Shared compare unit: equality for search and signed greater-than for sort.
module bass_cmp
    import bass_pkg::*;
(
    input  t_cmp_op                  i_op,
    input  logic    [DATA_W-1:0]     i_a,
    input  logic    [DATA_W-1:0]     i_b,
    output logic                     o_hit
);

    always_comb begin
        case (i_op)
            CMP_EQ:  o_hit = (i_a == i_b);
            CMP_SGT: o_hit = ($signed(i_a) > $signed(i_b));
            default: o_hit = 1'b0;
        endcase
    end

endmodule

// File: src/bass_chk.sv
// Port-level checker for the bounded array store, bound to the top level.
module bass_chk
    import bass_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_valid,
    input logic                     o_stall,
    input logic                     o_valid,
    input logic                     i_stall,
    input logic        [2:0]        o_status,
    input logic signed [DATA_W-1:0] o_data,
    input logic        [IDX_W-1:0]  o_index,
    input logic                     o_last
);

    // After reset the block is idle and shows no result.
    a_reset_idle : assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && !o_stall))
        else $error("block not idle after reset");

    // An accepted transaction keeps the block busy in the following cycle.
    a_busy_after_accept : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input not stalled after a transaction was accepted");

    // Only display produces several results, and all of them report success.
    a_multi_ok : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> (o_status == ST_OK))
        else $error("non-final result with an error status");

    // Error results are single, and carry zero data and index.
    a_error_clean : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> (o_last && o_data == '0 && o_index == '0))
        else $error("error result with stray fields");

    // A stalled result holds.
    a_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_data) && $stable(o_status)
                                  && $stable(o_index) && $stable(o_last)))
        else $error("stalled result changed");

endmodule

bind bounded_array_stack_search_sort_top bass_chk u_bass_chk (.*);

// File: bench/bounded_array_stack_search_sort_top_tb.sv
// Testbench for the bounded array store: directed and random operations checked against a predictor.
`timescale 1ns / 1ps

module bounded_array_stack_search_sort_top_tb;
    import bass_pkg::*;

    localparam logic [2:0] KIND_UNUSED5 = 3'd5;
    localparam logic [2:0] KIND_UNUSED6 = 3'd6;
    localparam logic [2:0] KIND_UNUSED7 = 3'd7;
    localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] VAL_MAX = ~VAL_MIN;
    localparam int RANDOM_OPS   = 79;
    localparam int HOLD_CYCLES  = 80;
    localparam int TAIL_CYCLES  = 100;
    localparam int WATCH_LIMIT  = 2000;

    typedef struct {
        t_status                  status;
        logic signed [DATA_W-1:0] data;
        logic [IDX_W-1:0]         index;
        logic                     last;
    } t_result;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_valid;
    logic                     o_stall;
    logic        [2:0]        i_kind;
    logic signed [DATA_W-1:0] i_value;
    logic                     o_valid;
    logic                     i_stall;
    logic        [2:0]        o_status;
    logic signed [DATA_W-1:0] o_data;
    logic        [IDX_W-1:0]  o_index;
    logic                     o_last;

    logic signed [DATA_W-1:0] store_mdl [CAPACITY];
    int                       fill_mdl;
    t_result                  expected_results [$];
    t_result                  head;
    int                       mismatches;
    int                       ops_sent;
    int                       results_seen;
    int                       hold_left;
    int                       quiet_cycles;
    logic                     hold_req;
    bit                       calm_stretch;

    bounded_array_stack_search_sort_top DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_kind   (i_kind),
        .i_value  (i_value),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_status (o_status),
        .o_data   (o_data),
        .o_index  (o_index),
        .o_last   (o_last)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    task automatic report_mismatch(input string what, input longint expv, input longint gotv);
        $display("MISMATCH %s: expected %0d, got %0d at %0t", what, expv, gotv, $realtime);
        mismatches++;
    endtask

    task automatic expect_result(input t_status st, input logic signed [DATA_W-1:0] data,
                                 input int idx, input logic last);
        t_result r;
        r.status = st;
        r.data   = data;
        r.index  = IDX_W'(idx);
        r.last   = last;
        expected_results.push_back(r);
    endtask

    task automatic predict_store_op(input logic [2:0] kind, input logic signed [DATA_W-1:0] value);
        int                       i;
        int                       j;
        int                       hit;
        logic signed [DATA_W-1:0] swap;
        case (kind)
            KIND_INSERT: begin
                if (fill_mdl >= CAPACITY) begin
                    expect_result(ST_FULL, '0, 0, 1'b1);
                end else begin
                    store_mdl[fill_mdl] = value;
                    fill_mdl++;
                    expect_result(ST_OK, value, 0, 1'b1);
                end
            end
            KIND_DELETE: begin
                if (fill_mdl == 0) begin
                    expect_result(ST_EMPTY, '0, 0, 1'b1);
                end else begin
                    fill_mdl--;
                    expect_result(ST_OK, store_mdl[fill_mdl], 0, 1'b1);
                end
            end
            KIND_DISPLAY: begin
                if (fill_mdl == 0) begin
                    expect_result(ST_EMPTY, '0, 0, 1'b1);
                end else begin
                    for (i = 0; i < fill_mdl; i++)
                        expect_result(ST_OK, store_mdl[i], i, (i == fill_mdl - 1));
                end
            end
            KIND_SEARCH: begin
                if (fill_mdl == 0) begin
                    expect_result(ST_EMPTY, '0, 0, 1'b1);
                end else begin
                    hit = -1;
                    for (i = 0; i < fill_mdl; i++)
                        if (hit < 0 && store_mdl[i] == value) hit = i;
                    if (hit < 0) expect_result(ST_NOTFOUND, '0, 0, 1'b1);
                    else expect_result(ST_OK, value, hit, 1'b1);
                end
            end
            KIND_SORT: begin
                if (fill_mdl == 0) begin
                    expect_result(ST_EMPTY, '0, 0, 1'b1);
                end else begin
                    for (i = 0; i < fill_mdl; i++) begin
                        for (j = i + 1; j < fill_mdl; j++) begin
                            if (store_mdl[i] > store_mdl[j]) begin
                                swap         = store_mdl[i];
                                store_mdl[i] = store_mdl[j];
                                store_mdl[j] = swap;
                            end
                        end
                    end
                    expect_result(ST_OK, '0, 0, 1'b1);
                end
            end
            default: expect_result(ST_INVALID, '0, 0, 1'b1);
        endcase
    endtask

    // Offers one operation and returns at the edge where it is accepted; valid stays high.
    task automatic send_op(input logic [2:0] kind, input logic signed [DATA_W-1:0] value);
        int gap;
        if (!calm_stretch && $urandom_range(99) < 27) begin
            i_valid <= 1'b0;
            gap = $urandom_range(1, 4);
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_kind  <= kind;
        i_value <= value;
        do @(posedge i_clk); while (o_stall);
        predict_store_op(kind, value);
        ops_sent++;
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(4))
            0: return $urandom;
            1: return DATA_W'($urandom_range(6)) - 3;
            2: return $urandom_range(1) ? VAL_MIN : VAL_MAX;
            default: return (fill_mdl > 0) ? store_mdl[$urandom_range(fill_mdl - 1)] : $urandom;
        endcase
    endfunction

    // Receiver: drives the stall, runs the long hold-off and checks every accepted result.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall   <= 1'b0;
            hold_left <= 0;
        end else begin
            if (o_valid && !i_stall) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result, data", 0, o_data);
                end else begin
                    head = expected_results.pop_front();
                    if (o_status !== head.status) report_mismatch("status", head.status, o_status);
                    if (o_data !== head.data) report_mismatch("data", head.data, o_data);
                    if (o_index !== head.index) report_mismatch("index", head.index, o_index);
                    if (o_last !== head.last) report_mismatch("last", head.last, o_last);
                end
            end
            if (hold_left > 0) begin
                i_stall   <= 1'b1;
                hold_left <= hold_left - 1;
            end else if (hold_req) begin
                i_stall   <= 1'b1;
                hold_left <= HOLD_CYCLES - 1;
                hold_req  <= 1'b0;
            end else begin
                i_stall <= !calm_stretch && ($urandom_range(99) < 27);
            end
        end
    end

    initial begin : watchdog
        quiet_cycles = 0;
        while (quiet_cycles < WATCH_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n) quiet_cycles = 0;
            else quiet_cycles++;
        end
        $display("Watchdog expired after %0d cycles without a transaction.", WATCH_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic test_empty_store();
        send_op(KIND_DELETE, VAL_MAX);
        send_op(KIND_DISPLAY, '0);
        send_op(KIND_SEARCH, '0);
        send_op(KIND_SORT, VAL_MIN);
        send_op(KIND_UNUSED5, '1);
        send_op(KIND_UNUSED6, VAL_MIN);
        send_op(KIND_UNUSED7, VAL_MAX);
    endtask

    task automatic test_fill_and_full();
        send_op(KIND_INSERT, VAL_MAX);
        send_op(KIND_INSERT, VAL_MIN);
        send_op(KIND_INSERT, '0);
        send_op(KIND_INSERT, -1);
        send_op(KIND_INSERT, 1);
        send_op(KIND_INSERT, 32'h5555_5555);
        send_op(KIND_INSERT, 32'hAAAA_AAAA);
        send_op(KIND_INSERT, 7);
        send_op(KIND_INSERT, 32'h0F0F_0F0F);
        send_op(KIND_DISPLAY, '0);
        send_op(KIND_SEARCH, -1);
        send_op(KIND_SEARCH, 32'h1234_5678);
    endtask

    task automatic test_sort_order();
        send_op(KIND_SORT, '0);
        send_op(KIND_DISPLAY, '0);
        send_op(KIND_SEARCH, VAL_MAX);
        send_op(KIND_DELETE, '0);
        send_op(KIND_DELETE, '0);
    endtask

    task automatic test_backpressure();
        send_op(KIND_INSERT, 3);
        send_op(KIND_INSERT, -3);
        hold_req <= 1'b1;
        send_op(KIND_DISPLAY, '0);
        send_op(KIND_SEARCH, 3);
        send_op(KIND_DISPLAY, '0);
        send_op(KIND_DELETE, '0);
        send_op(KIND_SORT, '0);
    endtask

    task automatic test_random_ops();
        int                       n;
        int                       pick;
        logic [2:0]               kind;
        logic signed [DATA_W-1:0] value;
        for (n = 0; n < RANDOM_OPS; n++) begin
            calm_stretch = (n >= 40 && n < 70);
            pick  = $urandom_range(99);
            value = pick_value();
            if (pick < 35) kind = KIND_INSERT;
            else if (pick < 55) kind = KIND_DELETE;
            else if (pick < 67) kind = KIND_DISPLAY;
            else if (pick < 85) kind = KIND_SEARCH;
            else if (pick < 93) kind = KIND_SORT;
            else kind = KIND_UNUSED5 + 3'($urandom_range(2));
            send_op(kind, value);
        end
        calm_stretch = 1'b0;
    endtask

    initial begin
        i_rst_n      <= 1'b0;
        i_valid      <= 1'b0;
        i_stall      <= 1'b0;
        i_kind       <= KIND_INSERT;
        i_value      <= '0;
        hold_req     <= 1'b0;
        calm_stretch  = 1'b0;
        fill_mdl      = 0;
        mismatches    = 0;
        ops_sent      = 0;
        results_seen  = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_store();
        test_fill_and_full();
        test_sort_order();
        test_backpressure();
        test_random_ops();
        i_valid <= 1'b0;

        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Run sent %0d operations and checked %0d results, covering empty, full,",
                 ops_sent, results_seen);
        $display("sorted, not-found and invalid-kind cases and a long receiver hold-off.");
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// File: sim.f
src/bass_pkg.sv
src/bass_cmp.sv
src/bounded_array_stack_search_sort_top.sv
src/bass_chk.sv
bench/bounded_array_stack_search_sort_top_tb.sv
